// ===== src/fse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the flow-shop schedule evaluator.
// No dependencies.
package fse_pkg;

   localparam int TIME_W  = 32;
   localparam int PTIME_W = 16;
   localparam int WGT_W   = 16;
   localparam int SUM_W   = 48;
   localparam int CNT_W   = 9;
   localparam int CFG_W   = 6;

   localparam logic [1:0] KIND_PTIME = 2'd0;
   localparam logic [1:0] KIND_DUE   = 2'd1;
   localparam logic [1:0] KIND_SEQ   = 2'd2;

   localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  job_id;
      logic [4:0]  machine_id;
      logic [15:0] proc_time;
      logic [31:0] due_date;
      logic [15:0] weight;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] makespan;
      logic [47:0] weighted_tardiness;
      logic [8:0]  job_count;
      logic        saturated;
   } rsp_type;

   // Token handed from one machine cell to the next.
   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] ctime;
   } tok_type;

endpackage

// ===== src/fse_cell.sv =====
`timescale 1ns / 1ps
// One machine cell: holds the completion time of the previous job on this machine.
// Depends on fse_pkg.
module fse_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              en,
   input  fse_pkg::tok_type                  tok_in,
   input  logic [fse_pkg::PTIME_W-1:0]       ptime,
   output fse_pkg::tok_type                  tok_out,
   output logic                              clip
);

   logic [fse_pkg::TIME_W-1:0] comp_ff;
   logic [fse_pkg::TIME_W-1:0] start;
   logic [fse_pkg::TIME_W:0]   total;
   logic [fse_pkg::TIME_W-1:0] done_in;
   logic                       valid_ff;
   logic [fse_pkg::TIME_W-1:0] ctime_ff;
   logic                       clip_ff;

   always_comb begin
      start   = (comp_ff > tok_in.ctime) ? comp_ff : tok_in.ctime;
      total   = {1'b0, start} + {{(fse_pkg::TIME_W-fse_pkg::PTIME_W+1){1'b0}}, ptime};
      done_in = total[fse_pkg::TIME_W] ? {fse_pkg::TIME_W{1'b1}}
                                       : total[fse_pkg::TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff  <= '0;
         valid_ff <= 1'b0;
         clip_ff  <= 1'b0;
      end else begin
         valid_ff <= tok_in.valid & en;
         clip_ff  <= tok_in.valid & en & total[fse_pkg::TIME_W];
         if (clear) begin
            comp_ff <= '0;
         end else if (tok_in.valid && en) begin
            comp_ff <= done_in;
         end
      end
      ctime_ff <= done_in;
   end

   assign tok_out.valid = valid_ff;
   assign tok_out.ctime = ctime_ff;
   assign clip          = clip_ff;

endmodule

// ===== src/flow_shop_schedule_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the flow-shop schedule evaluator: tables, sequencer, cell row.
// Depends on fse_pkg and fse_cell.

// Load requests (processing time, due date and weight) write their tables when
// taken. For a sequence request, one table read per machine is issued per
// cycle while the completion token walks the row of machine cells, then the
// lateness product and the saturating accumulate follow as separate steps. A
// result sits in its output register while further load requests are taken; a
// following final sequence request waits in the accumulate step until that
// result is gone.
module flow_shop_schedule_evaluator #(
   parameter int MAX_JOBS     = 256,
   parameter int MAX_MACHINES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  fse_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output fse_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fse_pkg::CFG_W-1:0]      csr_data
);

   localparam int JW     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int MW     = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int DEPTH  = MAX_JOBS * MAX_MACHINES;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW     = 9;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RUN  = 5'b00010,
      S_WAIT = 5'b00100,
      S_MUL  = 5'b01000,
      S_ACC  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [fse_pkg::CFG_W-1:0]   cfg_ff;
   logic [NW-1:0]               n_last;
   logic [MW-1:0]               n_idx;

   logic [fse_pkg::PTIME_W-1:0] time_mem [DEPTH];
   logic [fse_pkg::TIME_W-1:0]  due_mem  [MAX_JOBS];
   logic [fse_pkg::WGT_W-1:0]   wgt_mem  [MAX_JOBS];

   logic                        accept;
   logic                        job_ok;
   logic                        mach_ok;
   logic [JW-1:0]               job_idx;
   logic [MW-1:0]               mach_idx;

   logic [JW-1:0]               job_ff;
   logic                        job_ok_ff;
   logic                        last_ff;
   logic [MW-1:0]               rd_cnt_ff;
   logic                        launch_ff;
   logic [fse_pkg::PTIME_W-1:0] p_rd_ff;
   logic [fse_pkg::PTIME_W-1:0] p_use;
   logic [fse_pkg::TIME_W-1:0]  due_rd_ff;
   logic [fse_pkg::WGT_W-1:0]   wgt_rd_ff;
   logic [AW-1:0]               rd_addr;
   logic [AW-1:0]               wr_addr;

   fse_pkg::tok_type            tok_in  [MAX_MACHINES];
   fse_pkg::tok_type            tok_out [MAX_MACHINES];
   logic [MAX_MACHINES-1:0]     clip_vec;
   logic [MAX_MACHINES-1:0]     tok_vec;
   logic [MAX_MACHINES-1:0]     en_vec;
   logic                        row_clear;
   fse_pkg::tok_type            fin_tok;

   logic [fse_pkg::TIME_W-1:0]  fin_ff;
   logic [fse_pkg::TIME_W-1:0]  late;
   logic [fse_pkg::SUM_W-1:0]   prod_ff;
   logic [fse_pkg::SUM_W-1:0]   sum_ff;
   logic [fse_pkg::SUM_W:0]     sum_wide;
   logic [fse_pkg::SUM_W-1:0]   sum_new;
   logic [fse_pkg::CNT_W-1:0]   count_ff;
   logic [fse_pkg::CNT_W-1:0]   count_new;
   logic                        clip_ff;
   logic                        clip_new;
   logic                        acc_go;
   logic                        rsp_valid_ff;
   fse_pkg::rsp_type            rsp_ff;

   // Machine count, clamped to the row; a count of zero is treated as one.
   always_comb begin
      if (cfg_ff == '0) begin
         n_last = '0;
      end else if (NW'(cfg_ff) > NW'(MAX_MACHINES)) begin
         n_last = NW'(MAX_MACHINES - 1);
      end else begin
         n_last = NW'(cfg_ff) - NW'(1);
      end
      n_idx = n_last[MW-1:0];
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= fse_pkg::CFG_W'(1);
      end else if (csr_valid) begin
         cfg_ff <= csr_data;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign job_ok    = 32'(req_data.job_id) < 32'(MAX_JOBS);
   assign mach_ok   = 32'(req_data.machine_id) < 32'(MAX_MACHINES);
   assign job_idx   = JW'(req_data.job_id);
   assign mach_idx  = MW'(req_data.machine_id);
   assign wr_addr   = AW'(32'(job_idx) * MAX_MACHINES + 32'(mach_idx));
   assign rd_addr   = AW'(32'(job_ff) * MAX_MACHINES + 32'(rd_cnt_ff));

   // Table storage: one write port, registered reads.
   always_ff @(posedge clock) begin
      if (accept && req_data.kind == fse_pkg::KIND_PTIME && job_ok && mach_ok) begin
         time_mem[wr_addr] <= req_data.proc_time;
      end
      p_rd_ff <= time_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.kind == fse_pkg::KIND_DUE && job_ok) begin
         due_mem[job_idx] <= req_data.due_date;
         wgt_mem[job_idx] <= req_data.weight;
      end
      if (accept && req_data.kind == fse_pkg::KIND_SEQ) begin
         due_rd_ff <= due_mem[job_idx];
         wgt_rd_ff <= wgt_mem[job_idx];
      end
   end

   assign p_use = job_ok_ff ? p_rd_ff : '0;

   // Cell row.
   genvar g;
   generate
      for (g = 0; g < MAX_MACHINES; g++) begin : g_row
         if (g == 0) begin : g_head
            assign tok_in[g].valid = launch_ff;
            assign tok_in[g].ctime = '0;
         end else begin : g_link
            assign tok_in[g] = tok_out[g-1];
         end
         assign en_vec[g]  = (NW'(g) <= n_last);
         assign tok_vec[g] = tok_out[g].valid;
         fse_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (row_clear),
            .en      (en_vec[g]),
            .tok_in  (tok_in[g]),
            .ptime   (p_use),
            .tok_out (tok_out[g]),
            .clip    (clip_vec[g])
         );
      end
   endgenerate

   assign fin_tok = tok_out[n_idx];

   // Tardiness arithmetic.
   always_comb begin
      late      = (fin_ff > due_rd_ff) ? (fin_ff - due_rd_ff) : '0;
      sum_wide  = {1'b0, sum_ff} + {1'b0, prod_ff};
      sum_new   = sum_wide[fse_pkg::SUM_W] ? {fse_pkg::SUM_W{1'b1}}
                                           : sum_wide[fse_pkg::SUM_W-1:0];
      clip_new  = clip_ff | sum_wide[fse_pkg::SUM_W];
      count_new = (count_ff < fse_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
      acc_go    = (state_ff == S_ACC) && !(last_ff && rsp_valid_ff && !rsp_ready);
      row_clear = acc_go & last_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.kind == fse_pkg::KIND_SEQ) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (rd_cnt_ff == n_idx) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (fin_tok.valid) begin
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            if (acc_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_cnt_ff    <= '0;
         launch_ff    <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= (state_ff == S_RUN) && (rd_cnt_ff == '0);
         if (state_ff == S_RUN) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end else begin
            rd_cnt_ff <= '0;
         end
         if (acc_go && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (acc_go) begin
            if (last_ff) begin
               sum_ff   <= '0;
               count_ff <= '0;
               clip_ff  <= 1'b0;
            end else begin
               sum_ff   <= sum_new;
               count_ff <= count_new;
               clip_ff  <= clip_new;
            end
         end else if (|clip_vec) begin
            clip_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff    <= job_idx;
         job_ok_ff <= job_ok;
         last_ff   <= req_data.last;
      end
      if (state_ff == S_WAIT && fin_tok.valid) begin
         fin_ff <= fin_tok.ctime;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= fse_pkg::SUM_W'(late)
                    * fse_pkg::SUM_W'(job_ok_ff ? wgt_rd_ff : '0);
      end
      if (acc_go && last_ff) begin
         rsp_ff.makespan           <= fin_ff;
         rsp_ff.weighted_tardiness <= sum_new;
         rsp_ff.job_count          <= count_new;
         rsp_ff.saturated          <= clip_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // At most one token travels the row.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one token in the cell row");

   // A new result appears only from the accumulate step.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_ACC))
      else $error("result raised outside accumulate");

   // The final completion shows up only while waiting for it.
   a_fin_wait: assert property (@(posedge clock) disable iff (reset)
      fin_tok.valid |-> (state_ff == S_WAIT))
      else $error("final completion outside wait");

endmodule
